[src/tlffb_pkg.sv]
// shared types, constants and a helper function for the two-level free flow bitmap
`timescale 1ns / 1ps

package tlffb_pkg;

   localparam int NUM_ZONES_DEF = 32;
   localparam int ZONE_BITS     = 32;
   localparam int ZONE_IDX_W    = 5;
   localparam int FLOW_IDX_W    = 10;
   localparam int CMD_W         = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_FIND          = 2'd0,
      CMD_MARK_EMPTY    = 2'd1,
      CMD_MARK_OCCUPIED = 2'd2
   } cmd_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // transaction accepted: capture it and read the zone word
      logic exec;   // evaluate, write back and produce the result
   } ctrl_cmd_type;

   // index of the lowest set bit, 31 when none is set
   function automatic logic [ZONE_IDX_W-1:0] lowest_set(input logic [ZONE_BITS-1:0] v);
      logic [ZONE_IDX_W-1:0] b;
      b = ZONE_IDX_W'(ZONE_BITS - 1);
      for (int i = ZONE_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            b = ZONE_IDX_W'(i);
         end
      end
      return b;
   endfunction

endpackage

[src/tlffb_ctrl.sv]
// controller state machine: accepts transactions and sequences the datapath
`timescale 1ns / 1ps

module tlffb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output tlffb_pkg::ctrl_cmd_type ctrl_cmd,
   output logic                    rsp_strobe
);
   import tlffb_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      strobe_ff;

   assign busy          = (state_ff != ST_IDLE);
   assign ctrl_cmd.load = start && (state_ff == ST_IDLE);
   assign ctrl_cmd.exec = (state_ff == ST_EXEC);
   assign rsp_strobe    = strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               strobe_ff <= 1'b0;
               if (start) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               strobe_ff <= 1'b1;
               state_ff  <= ST_IDLE;
            end
            default: begin
               strobe_ff <= 1'b0;
               state_ff  <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[src/tlffb_datapath.sv]
// datapath: zone word memory, summary register, priority encoders and result registers
`timescale 1ns / 1ps

module tlffb_datapath #(
   parameter int NUM_ZONES = tlffb_pkg::NUM_ZONES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tlffb_pkg::ctrl_cmd_type              ctrl_cmd,
   input  logic [tlffb_pkg::CMD_W-1:0]          req_cmd,
   input  logic [tlffb_pkg::FLOW_IDX_W-1:0]     req_flow_index,
   output logic [tlffb_pkg::FLOW_IDX_W-1:0]     rsp_found_flow,
   output logic                                 rsp_none_empty
);
   import tlffb_pkg::*;

   localparam int ZONE_AW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
   localparam logic [ZONE_BITS-1:0] SUMMARY_RESET = ~({ZONE_BITS{1'b1}} >> NUM_ZONES);
   localparam logic [ZONE_BITS-1:0] TOP_BIT = {1'b1, {(ZONE_BITS-1){1'b0}}};

   logic [ZONE_BITS-1:0]  zone_mem [NUM_ZONES];
   logic [NUM_ZONES-1:0]  zone_valid_ff;
   logic [ZONE_BITS-1:0]  summary_ff;

   logic [ZONE_BITS-1:0]  rd_word_ff;
   logic                  rd_valid_ff;
   cmd_type               cmd_ff;
   logic [ZONE_IDX_W-1:0] zone_ff;
   logic [ZONE_IDX_W-1:0] bit_idx_ff;
   logic                  in_range_ff;
   logic [FLOW_IDX_W-1:0] found_ff;
   logic                  none_ff;

   logic [ZONE_IDX_W-1:0] req_zone;
   logic [ZONE_IDX_W-1:0] find_zone;
   logic [ZONE_IDX_W-1:0] sel_zone_in;
   logic [ZONE_AW-1:0]    rd_addr;
   logic [ZONE_AW-1:0]    wr_addr;
   logic                  req_in_range;
   logic [ZONE_BITS-1:0]  word;
   logic [ZONE_BITS-1:0]  flow_bit;
   logic [ZONE_BITS-1:0]  zone_bit;
   logic [ZONE_BITS-1:0]  new_word;
   logic                  do_write;
   logic [ZONE_BITS-1:0]  summary_in;
   logic [FLOW_IDX_W-1:0] found_in;
   logic                  none_in;

   assign req_zone     = req_flow_index[FLOW_IDX_W-1 -: ZONE_IDX_W];
   // zone z sits at summary bit 31-z, so the lowest set bit names the highest zone
   assign find_zone    = ZONE_IDX_W'(ZONE_BITS - 1) - lowest_set(summary_ff);
   assign req_in_range = ({1'b0, req_zone} < (ZONE_IDX_W + 1)'(NUM_ZONES));
   assign sel_zone_in  = (cmd_type'(req_cmd) == CMD_FIND) ? find_zone : req_zone;
   assign rd_addr      = sel_zone_in[ZONE_AW-1:0];
   assign wr_addr      = zone_ff[ZONE_AW-1:0];

   // a word never written reads as all ones through its cleared valid bit
   assign word     = rd_valid_ff ? rd_word_ff : {ZONE_BITS{1'b1}};
   assign flow_bit = TOP_BIT >> bit_idx_ff;
   assign zone_bit = TOP_BIT >> zone_ff;

   always_comb begin
      new_word   = word;
      do_write   = 1'b0;
      summary_in = summary_ff;
      found_in   = '0;
      none_in    = 1'b0;
      case (cmd_ff)
         CMD_FIND: begin
            if ((summary_ff == '0) || (word == '0)) begin
               none_in = 1'b1;
            end else begin
               found_in = {zone_ff, ZONE_IDX_W'(ZONE_BITS - 1) - lowest_set(word)};
            end
         end
         CMD_MARK_EMPTY: begin
            if (in_range_ff) begin
               new_word   = word | flow_bit;
               do_write   = 1'b1;
               summary_in = summary_ff | zone_bit;
            end
         end
         CMD_MARK_OCCUPIED: begin
            if (in_range_ff) begin
               new_word = word & ~flow_bit;
               do_write = 1'b1;
               if (new_word == '0) begin
                  summary_in = summary_ff & ~zone_bit;
               end
            end
         end
         default: begin
            new_word = word;
         end
      endcase
   end

   // zone word memory: read on accept, write back on evaluate
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         rd_word_ff <= zone_mem[rd_addr];
      end
      if (ctrl_cmd.exec && do_write) begin
         zone_mem[wr_addr] <= new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_valid_ff <= '0;
         summary_ff    <= SUMMARY_RESET;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (ctrl_cmd.load) begin
            rd_valid_ff <= zone_valid_ff[rd_addr];
         end
         if (ctrl_cmd.exec) begin
            summary_ff <= summary_in;
            if (do_write) begin
               zone_valid_ff[wr_addr] <= 1'b1;
            end
         end
      end
   end

   // captured transaction and result payload
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_ff      <= cmd_type'(req_cmd);
         zone_ff     <= sel_zone_in;
         bit_idx_ff  <= req_flow_index[ZONE_IDX_W-1:0];
         in_range_ff <= req_in_range;
      end
      if (ctrl_cmd.exec) begin
         found_ff <= found_in;
         none_ff  <= none_in;
      end
   end

   assign rsp_found_flow = found_ff;
   assign rsp_none_empty = none_ff;

endmodule

[src/two_level_free_flow_bitmap_top.sv]
// top level of the two-level free flow bitmap
`timescale 1ns / 1ps
//
// Tracks which of NUM_ZONES*32 flows are empty with one 32-bit word per zone
// and a summary word holding one bit per zone that has an empty flow.
// Command channel: a transaction is taken on a rising edge with start high and
// busy low. req_cmd selects find (highest-numbered empty flow), mark empty or
// mark occupied; req_flow_index names the flow for the marks.
// Result channel: every transaction gives one result, shown for exactly one
// cycle with rsp_strobe high. rsp_found_flow carries the flow on find,
// rsp_none_empty flags a find with no empty flow; marks return zeros.
// Result timing: rsp_strobe and the result registers are loaded together in the
// evaluate state, which follows the accepting edge.
// A new transaction is taken only once the last one is done; accepting it reads
// the zone word memory, and the evaluate state writes back and registers the result.
// busy is high during the evaluate state only.
// Reset: synchronous, active high; afterwards every flow reads as empty
// at once (per-zone valid bits stand in for the memory contents).
// The receiver cannot stall: a result is taken in the cycle it is shown.
//
module two_level_free_flow_bitmap_top #(
   parameter int NUM_ZONES = tlffb_pkg::NUM_ZONES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tlffb_pkg::CMD_W-1:0]      req_cmd,
   input  logic [tlffb_pkg::FLOW_IDX_W-1:0] req_flow_index,
   output logic                             rsp_strobe,
   output logic [tlffb_pkg::FLOW_IDX_W-1:0] rsp_found_flow,
   output logic                             rsp_none_empty
);
   import tlffb_pkg::*;

   ctrl_cmd_type ctrl_cmd;

   tlffb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .ctrl_cmd   (ctrl_cmd),
      .rsp_strobe (rsp_strobe)
   );

   tlffb_datapath #(
      .NUM_ZONES (NUM_ZONES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl_cmd       (ctrl_cmd),
      .req_cmd        (req_cmd),
      .req_flow_index (req_flow_index),
      .rsp_found_flow (rsp_found_flow),
      .rsp_none_empty (rsp_none_empty)
   );

endmodule
